### rtl/core/sgirle_pkg.sv
// Shared types and constants for the SGI run-length row encoder.
// Used by the front, the coder and the top level under rtl/core; depends on nothing else.
package sgirle_pkg;

  // Result kinds as seen on the kind port.
  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_ROW  = 2'd1,
    KIND_END  = 2'd2
  } kind_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_ROW_WIDTH   = 2'd0,
    REG_ROWS        = 2'd1,
    REG_PLANE_COUNT = 2'd2,
    REG_DATA_BASE   = 2'd3
  } reg_index_t;

  // Coder modes: nothing open, a repeat run open, a literal run open.
  typedef enum logic [1:0] {
    CM_IDLE = 2'd0,
    CM_RUN  = 2'd1,
    CM_LIT  = 2'd2
  } coder_mode_t;

  // Coder sequencer steps; each step writes at most one result.
  typedef enum logic [2:0] {
    BS_FEED        = 3'd0,
    BS_RUN_VAL     = 3'd1,
    BS_FLUSH       = 3'd2,
    BS_FLUSH_VAL   = 3'd3,
    BS_FLUSH_PATCH = 3'd4,
    BS_ROW         = 3'd5,
    BS_EOI         = 3'd6,
    BS_DONE        = 3'd7
  } back_state_t;

  localparam logic [6:0]  RUN_MAX           = 7'h7f;
  localparam logic [7:0]  LIT_FLAG          = 8'h80;
  localparam logic [15:0] ROW_WIDTH_RESET   = 16'd1;
  localparam logic [15:0] ROWS_RESET        = 16'd1;
  localparam logic [1:0]  PLANE_COUNT_RESET = 2'd1;
  localparam logic [31:0] DATA_BASE_RESET   = 32'h200;

  // Queue depths as address bits.
  localparam int MID_QUEUE_AW = 2;
  localparam int OUT_QUEUE_AW = 2;

  typedef struct packed {
    logic [15:0] row_width;
    logic [15:0] rows;
    logic [1:0]  plane_count;
    logic [31:0] data_base;
  } cfg_t;

  // One classified pixel between the front and the coder.
  typedef struct packed {
    logic [7:0]  pixel;
    logic        row_end;
    logic        img_end;
    logic [17:0] tidx;
  } item_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] address;
    logic [7:0]  value;
    logic [17:0] table_index;
    logic [16:0] row_length;
    logic        last;
  } result_t;

endpackage

### rtl/core/sgirle_fifo.sv
// Small first-word-fall-through queue built from registers.
// Generic; used between front and coder and on the result side.
module sgirle_fifo #(
  parameter int WIDTH  = 8,
  parameter int ADDR_W = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int DEPTH = 2 ** ADDR_W;

  logic [WIDTH-1:0]  mem [DEPTH];
  logic [ADDR_W-1:0] wr_ptr;
  logic [ADDR_W-1:0] rd_ptr;
  logic [ADDR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == (ADDR_W + 1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

### rtl/core/sgirle_front.sv
// Front of the encoder: takes pixel beats and tags row and image ends and the row-table slot.
// Depends on sgirle_pkg; feeds the queue in front of the coder.
module sgirle_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [7:0]       pixel,
  output logic             full,
  input  sgirle_pkg::cfg_t cfg,
  output logic             q_push,
  output sgirle_pkg::item_t q_item,
  input  logic             q_full
);

  import sgirle_pkg::*;

  logic [15:0] column;
  logic [15:0] row_index;
  logic [1:0]  plane;

  logic [15:0] w;
  logic [15:0] h;
  logic [1:0]  pc;
  logic [15:0] col_inc;
  logic [15:0] row_inc;
  logic [1:0]  plane_inc;
  logic [15:0] from_bottom;
  logic [17:0] plane_h;
  logic        row_end;
  logic        plane_end;
  logic        img_end;

  assign full   = q_full;
  assign q_push = push && !q_full;

  // Zero registers act as one.
  assign w  = (cfg.row_width == '0) ? 16'd1 : cfg.row_width;
  assign h  = (cfg.rows == '0) ? 16'd1 : cfg.rows;
  assign pc = (cfg.plane_count == '0) ? 2'd1 : cfg.plane_count;

  // Position tests use "reached or passed" so mid-image register changes settle.
  assign col_inc   = column + 16'd1;
  assign row_inc   = row_index + 16'd1;
  assign plane_inc = plane + 2'd1;
  assign row_end   = (col_inc == '0) || (col_inc >= w);
  assign plane_end = (row_inc == '0) || (row_inc >= h);
  assign img_end   = row_end && plane_end && ((plane_inc == '0) || (plane_inc >= pc));

  // Row-table slot: plane times rows plus the row counted from the bottom.
  assign from_bottom = (row_index < h) ? (h - 16'd1 - row_index) : 16'd0;
  assign plane_h     = ({2'b00, h} & {18{plane[0]}}) + ({1'b0, h, 1'b0} & {18{plane[1]}});

  always_comb begin
    q_item.pixel   = pixel;
    q_item.row_end = row_end;
    q_item.img_end = img_end;
    q_item.tidx    = plane_h + {2'b00, from_bottom};
  end

  // Pixel position counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      column    <= '0;
      row_index <= '0;
      plane     <= '0;
    end else if (q_push) begin
      if (row_end) begin
        column <= '0;
        if (plane_end) begin
          row_index <= '0;
          plane     <= img_end ? 2'd0 : plane_inc;
        end else begin
          row_index <= row_inc;
        end
      end else begin
        column <= col_inc;
      end
    end
  end

`ifndef ASSERT_OFF
  // An image end returns the position to the first pixel.
  a_img_end_restart: assert property (@(posedge clk) disable iff (rst)
    (q_push && q_item.img_end) |=> (column == '0 && row_index == '0 && plane == '0))
    else $error("position not cleared after image end");
`endif

endmodule

### rtl/core/sgirle_back.sv
// Coder of the encoder: runs the RLE state and writes at most one result per step.
// Depends on sgirle_pkg; reads the item queue and fills the result queue.
module sgirle_back #(
  parameter int ADDR_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  sgirle_pkg::item_t   q_item,
  input  logic                q_empty,
  output logic                q_pop,
  output sgirle_pkg::result_t out_data,
  output logic                out_push,
  input  logic                out_full,
  input  logic                base_load,
  input  logic [31:0]         base_value,
  input  logic [31:0]         data_base
);

  import sgirle_pkg::*;

  localparam logic [ADDR_BITS-1:0] A_ONE = ADDR_BITS'(1);
  localparam logic [ADDR_BITS-1:0] A_TWO = ADDR_BITS'(2);

  back_state_t          state, state_next;
  coder_mode_t          mode, mode_next;
  logic [7:0]           la0, la0_next;
  logic [7:0]           la1, la1_next;
  logic [1:0]           held, held_next;
  logic [7:0]           rv, rv_next;
  logic [6:0]           rl, rl_next;
  logic [ADDR_BITS-1:0] cnt_addr, cnt_addr_next;
  logic [ADDR_BITS-1:0] wp, wp_next;
  logic [ADDR_BITS-1:0] row_start, row_start_next;
  logic [7:0]           rbuf [3];
  logic [7:0]           rbuf_next [3];
  logic [1:0]           rcount, rcount_next;
  logic [7:0]           carry, carry_next;
  logic                 cur_row_end;
  logic                 cur_eoi;
  logic [17:0]          cur_tidx;
  result_t              pend, pend_next;
  logic                 pend_valid, pend_valid_next;

  logic                 src_q;
  logic [7:0]           b;
  logic                 step_go;
  logic                 emit;
  result_t              emit_res;
  logic                 feed_done;
  logic                 feed_row_end;
  logic                 end_item;
  logic [ADDR_BITS-1:0] row_diff;
  logic [31:0]          row_diff32;

  function automatic result_t byte_res(input logic [ADDR_BITS-1:0] addr,
                                       input logic [7:0] val);
    result_t r;
    r         = '0;
    r.kind    = KIND_BYTE;
    r.address = 32'(addr);
    r.value   = val;
    return r;
  endfunction

  // Bytes replayed after a literal closes come first, then the item queue.
  assign src_q      = (rcount == 2'd0);
  assign b          = src_q ? q_item.pixel : rbuf[0];
  assign step_go    = !out_full && !(state == BS_FEED && src_q && q_empty);
  assign row_diff   = wp - row_start;
  assign row_diff32 = 32'(row_diff);

  // Sequencer: next state, coder updates and result hand-off.
  always_comb begin
    state_next      = state;
    mode_next       = mode;
    la0_next        = la0;
    la1_next        = la1;
    held_next       = held;
    rv_next         = rv;
    rl_next         = rl;
    cnt_addr_next   = cnt_addr;
    wp_next         = wp;
    row_start_next  = row_start;
    rbuf_next       = rbuf;
    rcount_next     = rcount;
    carry_next      = carry;
    pend_next       = pend;
    pend_valid_next = pend_valid;
    emit            = 1'b0;
    emit_res        = '0;
    feed_done       = 1'b0;
    feed_row_end    = cur_row_end;
    end_item        = 1'b0;
    q_pop           = 1'b0;
    out_push        = 1'b0;
    out_data        = pend;
    out_data.last   = 1'b0;

    if (step_go) begin
      unique case (state)
        BS_FEED: begin
          q_pop        = src_q;
          feed_row_end = src_q ? q_item.row_end : cur_row_end;
          if (!src_q) begin
            rbuf_next[0] = rbuf[1];
            rbuf_next[1] = rbuf[2];
            rcount_next  = rcount - 2'd1;
          end
          unique case (mode)
            CM_LIT: begin
              if (held < 2'd2) begin
                if (held == 2'd0) begin
                  la0_next = b;
                end else begin
                  la1_next = b;
                end
                held_next = held + 2'd1;
              end else if (rl == RUN_MAX || (la0 == la1 && la1 == b)) begin
                // Close the literal and code its lookahead bytes again.
                emit         = 1'b1;
                emit_res     = byte_res(cnt_addr, LIT_FLAG | {1'b0, rl});
                mode_next    = CM_IDLE;
                held_next    = 2'd0;
                rbuf_next[0] = la0;
                rbuf_next[1] = la1;
                rbuf_next[2] = b;
                rcount_next  = 2'd3;
              end else begin
                emit     = 1'b1;
                emit_res = byte_res(wp, la0);
                wp_next  = wp + A_ONE;
                rl_next  = rl + 7'd1;
                la0_next = la1;
                la1_next = b;
              end
            end
            CM_RUN: begin
              if (b == rv && rl != RUN_MAX) begin
                rl_next = rl + 7'd1;
              end else if (rl > 7'd1) begin
                // Run ends: count byte now, value byte next step.
                emit       = 1'b1;
                emit_res   = byte_res(wp, {1'b0, rl});
                wp_next    = wp + A_ONE;
                carry_next = b;
                state_next = BS_RUN_VAL;
              end else begin
                // Single byte opens a literal; its count byte is reserved.
                cnt_addr_next = wp;
                emit          = 1'b1;
                emit_res      = byte_res(wp + A_ONE, rv);
                wp_next       = wp + A_TWO;
                rl_next       = 7'd1;
                la0_next      = b;
                held_next     = 2'd1;
                mode_next     = CM_LIT;
              end
            end
            default: begin
              rv_next   = b;
              rl_next   = 7'd1;
              held_next = 2'd0;
              mode_next = CM_RUN;
            end
          endcase
          feed_done = (rcount_next == 2'd0) && (state_next == BS_FEED);
        end

        BS_RUN_VAL: begin
          emit       = 1'b1;
          emit_res   = byte_res(wp, rv);
          wp_next    = wp + A_ONE;
          rv_next    = carry;
          rl_next    = 7'd1;
          state_next = BS_FEED;
          feed_done  = (rcount == 2'd0);
        end

        BS_FLUSH: begin
          unique case (mode)
            CM_LIT: begin
              if (held != 2'd0 && rl != RUN_MAX) begin
                emit      = 1'b1;
                emit_res  = byte_res(wp, la0);
                wp_next   = wp + A_ONE;
                rl_next   = rl + 7'd1;
                la0_next  = la1;
                held_next = held - 2'd1;
              end else begin
                emit      = 1'b1;
                emit_res  = byte_res(cnt_addr, LIT_FLAG | {1'b0, rl});
                mode_next = CM_IDLE;
                held_next = 2'd0;
                if (held != 2'd0) begin
                  // A full literal leaves bytes that start a new code.
                  rbuf_next[0] = la0;
                  rbuf_next[1] = la1;
                  rcount_next  = held;
                  state_next   = BS_FEED;
                end else begin
                  state_next = BS_ROW;
                end
              end
            end
            CM_RUN: begin
              if (rl > 7'd1) begin
                emit       = 1'b1;
                emit_res   = byte_res(wp, {1'b0, rl});
                wp_next    = wp + A_ONE;
                state_next = BS_FLUSH_VAL;
              end else begin
                cnt_addr_next = wp;
                emit          = 1'b1;
                emit_res      = byte_res(wp + A_ONE, rv);
                wp_next       = wp + A_TWO;
                rl_next       = 7'd1;
                state_next    = BS_FLUSH_PATCH;
              end
            end
            default: begin
              held_next  = 2'd0;
              mode_next  = CM_IDLE;
              state_next = BS_ROW;
            end
          endcase
        end

        BS_FLUSH_VAL: begin
          emit       = 1'b1;
          emit_res   = byte_res(wp, rv);
          wp_next    = wp + A_ONE;
          mode_next  = CM_IDLE;
          state_next = BS_ROW;
        end

        BS_FLUSH_PATCH: begin
          emit       = 1'b1;
          emit_res   = byte_res(cnt_addr, LIT_FLAG | {1'b0, rl});
          mode_next  = CM_IDLE;
          state_next = BS_ROW;
        end

        BS_ROW: begin
          emit                 = 1'b1;
          emit_res             = '0;
          emit_res.kind        = KIND_ROW;
          emit_res.address     = 32'(row_start);
          emit_res.table_index = cur_tidx;
          emit_res.row_length  = row_diff32[16:0];
          row_start_next       = wp;
          if (cur_eoi) begin
            state_next = BS_EOI;
          end else begin
            end_item = 1'b1;
          end
        end

        BS_EOI: begin
          emit             = 1'b1;
          emit_res         = '0;
          emit_res.kind    = KIND_END;
          emit_res.address = 32'(wp);
          wp_next          = data_base[ADDR_BITS-1:0];
          row_start_next   = data_base[ADDR_BITS-1:0];
          end_item         = 1'b1;
        end

        BS_DONE: begin
          out_push        = 1'b1;
          out_data.last   = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = BS_FEED;
        end
      endcase

      if (feed_done) begin
        if (feed_row_end) begin
          state_next = BS_FLUSH;
        end else begin
          end_item = 1'b1;
        end
      end

      // A new result pushes the held one out; at an item end the held one carries last.
      if (emit) begin
        out_push        = pend_valid;
        pend_next       = emit_res;
        pend_valid_next = 1'b1;
      end
      if (end_item) begin
        if (emit) begin
          state_next = BS_DONE;
        end else begin
          state_next = BS_FEED;
          if (pend_valid) begin
            out_push        = 1'b1;
            out_data.last   = 1'b1;
            pend_valid_next = 1'b0;
          end
        end
      end
    end

    // Writing data_base also moves the write pointer and the row start.
    if (base_load) begin
      wp_next        = base_value[ADDR_BITS-1:0];
      row_start_next = base_value[ADDR_BITS-1:0];
    end
  end

  // Control and coder state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BS_FEED;
      mode       <= CM_IDLE;
      la0        <= '0;
      la1        <= '0;
      held       <= '0;
      rv         <= '0;
      rl         <= '0;
      cnt_addr   <= '0;
      wp         <= DATA_BASE_RESET[ADDR_BITS-1:0];
      row_start  <= DATA_BASE_RESET[ADDR_BITS-1:0];
      rcount     <= '0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      mode       <= mode_next;
      la0        <= la0_next;
      la1        <= la1_next;
      held       <= held_next;
      rv         <= rv_next;
      rl         <= rl_next;
      cnt_addr   <= cnt_addr_next;
      wp         <= wp_next;
      row_start  <= row_start_next;
      rcount     <= rcount_next;
      pend_valid <= pend_valid_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    rbuf  <= rbuf_next;
    carry <= carry_next;
    pend  <= pend_next;
    if (q_pop) begin
      cur_row_end <= q_item.row_end;
      cur_eoi     <= q_item.img_end;
      cur_tidx    <= q_item.tidx;
    end
  end

`ifndef ASSERT_OFF
  // Every item's results are closed off before the next item starts.
  a_item_start_clean: assert property (@(posedge clk) disable iff (rst)
    (state == BS_FEED && rcount == 2'd0) |-> !pend_valid)
    else $error("held result left over at item start");

  // The closing step always has a result to mark as last.
  a_done_has_result: assert property (@(posedge clk) disable iff (rst)
    (state == BS_DONE) |-> pend_valid)
    else $error("closing step without a held result");

  // The second byte of a finished run only follows an open run.
  a_run_val_mode: assert property (@(posedge clk) disable iff (rst)
    (state == BS_RUN_VAL) |-> (mode == CM_RUN))
    else $error("run value step outside a run");

  // Results enter the result queue only while it has room.
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    out_push |-> !out_full)
    else $error("result pushed into a full queue");
`endif

endmodule

### rtl/core/sgi_rle_row_encoder.sv
// Top level of the SGI run-length row encoder: registers, front, queues, coder.
// Depends on sgirle_pkg, sgirle_front, sgirle_fifo and sgirle_back.
//
//   Channel   Direction  Handshake              Payload
//   pixel     in         push / full            pixel
//   result    out        empty / pop            kind address value table_index
//                                               row_length last
//   config    in         cfg_write              cfg_index cfg_data
//
// Each coder step writes at most one result. Closing a literal replays three
// bytes through the coder, one step each; a row end adds a step per extra
// result, at most seven results for one byte.
// Reset is synchronous and clears position, coder and both queues.
// full follows the four-beat item queue; the coder stalls on a full result queue.
module sgi_rle_row_encoder #(
  parameter int ADDR_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  pixel,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind,
  output logic [31:0] address,
  output logic [7:0]  value,
  output logic [17:0] table_index,
  output logic [16:0] row_length,
  output logic        last
);

  import sgirle_pkg::*;

  cfg_t    cfg;
  item_t   front_item;
  item_t   mid_item;
  result_t back_res;
  result_t out_res;
  logic    front_push;
  logic    mid_full;
  logic    mid_empty;
  logic    mid_pop;
  logic    out_push;
  logic    out_full;
  logic    base_load;

  assign base_load = cfg_write && (reg_index_t'(cfg_index) == REG_DATA_BASE);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row_width   <= ROW_WIDTH_RESET;
      cfg.rows        <= ROWS_RESET;
      cfg.plane_count <= PLANE_COUNT_RESET;
      cfg.data_base   <= DATA_BASE_RESET;
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_ROW_WIDTH:   cfg.row_width   <= cfg_data[15:0];
        REG_ROWS:        cfg.rows        <= cfg_data[15:0];
        REG_PLANE_COUNT: cfg.plane_count <= cfg_data[1:0];
        REG_DATA_BASE:   cfg.data_base   <= cfg_data;
      endcase
    end
  end

  sgirle_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .pixel  (pixel),
    .full   (full),
    .cfg    (cfg),
    .q_push (front_push),
    .q_item (front_item),
    .q_full (mid_full)
  );

  // Item queue between front and coder.
  sgirle_fifo #(
    .WIDTH  ($bits(item_t)),
    .ADDR_W (MID_QUEUE_AW)
  ) u_mid_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (front_push),
    .wdata (front_item),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_item),
    .empty (mid_empty)
  );

  sgirle_back #(
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_item     (mid_item),
    .q_empty    (mid_empty),
    .q_pop      (mid_pop),
    .out_data   (back_res),
    .out_push   (out_push),
    .out_full   (out_full),
    .base_load  (base_load),
    .base_value (cfg_data),
    .data_base  (cfg.data_base)
  );

  // Result queue toward the consumer.
  sgirle_fifo #(
    .WIDTH  ($bits(result_t)),
    .ADDR_W (OUT_QUEUE_AW)
  ) u_out_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (back_res),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_res),
    .empty (empty)
  );

  assign kind        = out_res.kind;
  assign address     = out_res.address;
  assign value       = out_res.value;
  assign table_index = out_res.table_index;
  assign row_length  = out_res.row_length;
  assign last        = out_res.last;

endmodule
